/* sv/vrpr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vrpr_pkg
// Shared types and constants of the VLAN rule priority rewriter.
// ----------------------------------------------------------------------------
package vrpr_pkg;

  // entry and rule field widths
  localparam int VID_W  = 13;
  localparam int PRI_W  = 4;
  localparam int CODE_W = 5;
  localparam int ACT_W  = 6;

  // one stored rule: {treat_new, pri_new, pri_match, vid}
  localparam int RULE_W = VID_W + 3 * CODE_W;

  // packed input tdata width and packed output tdata width
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 8;

  // widest count that the rule index logic works in
  localparam int WIDE_CNT_W = 7;

  // entry codes
  localparam logic [PRI_W-1:0]  PRI_SINGLE_TAG  = 4'hf;
  localparam logic [PRI_W-1:0]  PRI_DEFAULT_MIN = 4'he;
  localparam logic [CODE_W-1:0] PRI_NEW_DROP    = 5'b11110;

  // controller to datapath
  typedef struct packed {
    logic wr_rule;     // store the rule of the current request
    logic load_entry;  // latch the entry of the current request
    logic rd_en;       // read the rule at the scan index
    logic apply;       // rewrite the entry with the rule just read
    logic step;        // advance the scan index
    logic emit;        // move the result into the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_rule_write;  // request on the input is a rule write
    logic needs_scan;     // request on the input must go through the rules
    logic match;          // rule just read applies to the entry
    logic drop;           // that rule drops the entry
    logic last;           // scan index is the last rule in force
  } sts_t;

endpackage : vrpr_pkg
`default_nettype wire

/* sv/vrpr_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vrpr_ctrl
// Sequencer of the rule rewriter: accepts requests, walks the rule table
// one rule at a time and hands finished results to the output register.
// ----------------------------------------------------------------------------
module vrpr_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  input  wire vrpr_pkg::sts_t sts,
  output vrpr_pkg::cmd_t     cmd
);
  import vrpr_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_READ  = 4'b0010,
    S_CHECK = 4'b0100,
    S_EMIT  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   in_acc;
  logic   out_free;

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (sts.is_rule_write) begin
            cmd.wr_rule = 1'b1;
          end else begin
            cmd.load_entry = 1'b1;
            state_nxt      = sts.needs_scan ? S_READ : S_EMIT;
          end
        end
      end
      S_READ: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (sts.match) begin
          if (sts.drop) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.apply = 1'b1;
            state_nxt = S_EMIT;
          end
        end else if (sts.last) begin
          state_nxt = S_EMIT;
        end else begin
          cmd.step  = 1'b1;
          state_nxt = S_READ;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // output valid flag
  always_comb begin
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTHESIS
  // a result never overwrites one that is still waiting
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || out_tready))
    else $error("result loaded over a pending result");

  // a rule read is always followed by its compare
  a_read_check: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_en |=> (state_r == S_CHECK))
    else $error("rule read not followed by compare");

  // a miss on a rule that is not the last goes on to the next rule
  a_miss_next: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHECK && !sts.match && !sts.last) |=> (state_r == S_READ))
    else $error("scan stopped early");
`endif

endmodule : vrpr_ctrl
`default_nettype wire

/* sv/vrpr_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vrpr_datapath
// Rule memory, active count register, scan index, entry registers,
// rule compare and output register of the rule rewriter.
// ----------------------------------------------------------------------------
module vrpr_datapath #(
  parameter int MAX_RULES = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic [0:0]                        in_tuser,
  input  wire logic [vrpr_pkg::IN_DATA_W-1:0]    in_tdata,
  output logic [vrpr_pkg::OUT_DATA_W-1:0]        out_tdata,
  output logic [0:0]                             out_tuser,
  input  wire logic                              cfg_valid,
  input  wire logic [vrpr_pkg::ACT_W-1:0]        cfg_data,
  input  wire vrpr_pkg::cmd_t                    cmd,
  output vrpr_pkg::sts_t                         sts
);
  import vrpr_pkg::*;

  localparam int IDX_W = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam int CNT_W = $clog2(MAX_RULES + 1);

  // unpacked request fields
  logic [4:0]              rule_index;
  logic [VID_W-1:0]        rule_vid;
  logic signed [CODE_W-1:0] rule_pri_match;
  logic signed [CODE_W-1:0] rule_pri_new;
  logic signed [CODE_W-1:0] rule_treat_new;
  logic [PRI_W-1:0]        outer_pri_filter;
  logic [PRI_W-1:0]        inner_pri_filter;
  logic [VID_W-1:0]        inner_vid_filter;
  logic [PRI_W-1:0]        inner_pri_treat;

  assign rule_index       = in_tdata[4:0];
  assign rule_vid         = in_tdata[17:5];
  assign rule_pri_match   = in_tdata[22:18];
  assign rule_pri_new     = in_tdata[27:23];
  assign rule_treat_new   = in_tdata[32:28];
  assign outer_pri_filter = in_tdata[36:33];
  assign inner_pri_filter = in_tdata[40:37];
  assign inner_vid_filter = in_tdata[53:41];
  assign inner_pri_treat  = in_tdata[57:54];

  // active rule count, clamped to the table depth
  logic [ACT_W-1:0]      active_r;
  logic [WIDE_CNT_W-1:0] act_wide;
  logic [WIDE_CNT_W-1:0] lim_wide;
  logic [CNT_W-1:0]      lim;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= '0;
    end else if (cfg_valid) begin
      active_r <= cfg_data;
    end
  end

  assign act_wide = {1'b0, active_r};
  assign lim_wide = (act_wide > WIDE_CNT_W'(MAX_RULES)) ? WIDE_CNT_W'(MAX_RULES) : act_wide;
  assign lim      = lim_wide[CNT_W-1:0];

  // rule memory, single write port and registered read
  logic [RULE_W-1:0]     mem [MAX_RULES];
  logic [RULE_W-1:0]     rdata_r;
  logic [WIDE_CNT_W-1:0] wr_idx_wide;
  logic [IDX_W-1:0]      wr_addr;
  logic                  wr_ok;
  logic [CNT_W-1:0]      idx_r, idx_nxt;
  logic [IDX_W-1:0]      rd_addr;

  assign wr_idx_wide = {2'b00, rule_index};
  assign wr_addr     = wr_idx_wide[IDX_W-1:0];
  assign wr_ok       = (wr_idx_wide < WIDE_CNT_W'(MAX_RULES));
  assign rd_addr     = idx_r[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.wr_rule && wr_ok) begin
      mem[wr_addr] <= {rule_treat_new, rule_pri_new, rule_pri_match, rule_vid};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // scan index
  always_comb begin
    idx_nxt = idx_r;
    if (cmd.load_entry) begin
      idx_nxt = '0;
    end else if (cmd.step) begin
      idx_nxt = idx_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

  // entry and working result registers
  logic [VID_W-1:0] vid_r;
  logic [PRI_W-1:0] pri_r;
  logic [PRI_W-1:0] treat_r;
  logic             hit_r;

  logic [VID_W-1:0]  rd_vid;
  logic [CODE_W-1:0] rd_pm;
  logic [CODE_W-1:0] rd_pn;
  logic [CODE_W-1:0] rd_tn;

  assign rd_vid = rdata_r[VID_W-1:0];
  assign rd_pm  = rdata_r[VID_W +: CODE_W];
  assign rd_pn  = rdata_r[VID_W + CODE_W +: CODE_W];
  assign rd_tn  = rdata_r[VID_W + 2 * CODE_W +: CODE_W];

  always_ff @(posedge clk) begin
    if (cmd.load_entry) begin
      vid_r   <= inner_vid_filter;
      pri_r   <= inner_pri_filter;
      treat_r <= inner_pri_treat;
      hit_r   <= 1'b0;
    end else if (cmd.apply) begin
      // a negative code keeps the field
      if (!rd_pn[CODE_W-1]) begin
        pri_r <= rd_pn[PRI_W-1:0];
      end
      if (!rd_tn[CODE_W-1]) begin
        treat_r <= rd_tn[PRI_W-1:0];
      end
      hit_r <= 1'b1;
    end
  end

  // status toward the controller
  logic rule_applies;
  logic [CNT_W-1:0] idx_inc;

  assign rule_applies = (rd_vid == vid_r) &&
                        (rd_pm[CODE_W-1] || (rd_pm == {1'b0, pri_r}));
  assign idx_inc      = idx_r + CNT_W'(1);

  always_comb begin
    sts               = '0;
    sts.is_rule_write = in_tuser[0];
    sts.needs_scan    = (outer_pri_filter == PRI_SINGLE_TAG) &&
                        (inner_pri_filter < PRI_DEFAULT_MIN) &&
                        (lim != '0);
    sts.match         = rule_applies;
    sts.drop          = (rd_pn == PRI_NEW_DROP);
    sts.last          = (idx_inc == lim);
  end

  // output register
  logic [OUT_DATA_W-1:0] out_data_r;
  logic                  out_hit_r;

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r <= {treat_r, pri_r};
      out_hit_r  <= hit_r;
    end
  end

  assign out_tdata = out_data_r;
  assign out_tuser = out_hit_r;

endmodule : vrpr_datapath
`default_nettype wire

/* sv/vlan_rule_priority_rewriter_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vlan_rule_priority_rewriter_unit
// Filters VLAN tagging table entries through a table of rewrite rules.
// ----------------------------------------------------------------------------
// A rule write request (in_tuser = 1) is stored on acceptance and the block
// is ready again right after it. A classify request (in_tuser = 0) for a
// two-tagged or default entry, or with no rules in force, goes straight to
// S_EMIT and gives its result once the output register is free. Any other
// entry walks the rule table from slot 0 and stops at the first rule that
// applies, looking at no more rules than the active count (itself clamped to
// MAX_RULES). Each rule is read from the rule memory in S_READ and compared
// in S_CHECK. A dropped entry gives no result. The result sits in an
// output register, so the next request is taken while it waits. Rule slots
// are undefined until written and there is no clearing pass after reset.
// ----------------------------------------------------------------------------
module vlan_rule_priority_rewriter_unit #(
  parameter int MAX_RULES = 32
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // in_tuser: action (0 classify, 1 write rule)
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [0:0]                     in_tuser,
  // in_tdata from bit 0: rule_index(5), rule_vid(13), rule_pri_match(5),
  // rule_pri_new(5), rule_treat_new(5), outer_pri_filter(4),
  // inner_pri_filter(4), inner_vid_filter(13), inner_pri_treat(4), zeros(6)
  input  wire logic [vrpr_pkg::IN_DATA_W-1:0] in_tdata,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // out_tdata from bit 0: out_pri_filter(4), out_pri_treat(4)
  output logic [vrpr_pkg::OUT_DATA_W-1:0]     out_tdata,
  // out_tuser: rule_hit
  output logic [0:0]                          out_tuser,
  // cfg_data: active_rules
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [vrpr_pkg::ACT_W-1:0]     cfg_data
);
  import vrpr_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  // sequencer
  vrpr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // rule storage and compare
  vrpr_datapath #(
    .MAX_RULES (MAX_RULES)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule : vlan_rule_priority_rewriter_unit
`default_nettype wire

/* bench/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the VLAN rule priority rewriter. A queue of
// requests (rule writes and table entries) feeds a clocked driver. Each
// accepted request updates a local copy of the rule table or predicts the
// rewritten entry. A clocked monitor checks every result against the oldest
// prediction. The active rule count is changed only while the block is idle.
// ----------------------------------------------------------------------------
module testbench;
  import vrpr_pkg::*;

  localparam int MAX_RULES   = 32;
  localparam int STALL_LIMIT = 3000;
  // longest rule walk plus margin, used before a register write and at the end
  localparam int SETTLE_CYC  = 2 + 2 * MAX_RULES + 16;
  localparam int RAND_ITEMS  = 170;

  localparam logic ACT_CLASSIFY   = 1'b0;
  localparam logic ACT_WRITE_RULE = 1'b1;

  // codes used by the directed rules
  localparam logic [CODE_W-1:0] CODE_ANY  = 5'b11111;
  localparam logic [CODE_W-1:0] CODE_KEEP = 5'b11111;
  localparam logic [CODE_W-1:0] CODE_NEG  = 5'b10000;

  typedef struct {
    logic              act;
    logic [4:0]        idx;
    logic [VID_W-1:0]  rule_vid;
    logic [CODE_W-1:0] pri_match;
    logic [CODE_W-1:0] pri_new;
    logic [CODE_W-1:0] treat_new;
    logic [PRI_W-1:0]  outer_pri;
    logic [PRI_W-1:0]  inner_pri;
    logic [VID_W-1:0]  inner_vid;
    logic [PRI_W-1:0]  inner_treat;
  } vlan_req_t;

  typedef struct {
    logic [VID_W-1:0]  vid;
    logic [CODE_W-1:0] pri_match;
    logic [CODE_W-1:0] pri_new;
    logic [CODE_W-1:0] treat_new;
  } rule_slot_t;

  typedef struct {
    logic [PRI_W-1:0] pri;
    logic [PRI_W-1:0] treat;
    logic             hit;
  } entry_res_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [0:0]            in_tuser   = '0;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [0:0]            out_tuser;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [ACT_W-1:0]      cfg_data   = '0;

  // local copy of the block state
  rule_slot_t       rule_copy [MAX_RULES];
  logic [ACT_W-1:0] active_copy = '0;

  vlan_req_t  req_queue[$];
  entry_res_t rewritten_q[$];
  vlan_req_t  req_on_bus;
  logic       slot_written [MAX_RULES];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned err_cnt       = 0;
  int unsigned stall_cycles  = 0;
  logic [VID_W-1:0] vid_pool [6];

  vlan_rule_priority_rewriter_unit #(
    .MAX_RULES(MAX_RULES)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // clock, 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // pack request fields into tdata, first field lowest
  function automatic logic [IN_DATA_W-1:0] pack_req(input vlan_req_t r);
    return {6'b0, r.inner_treat, r.inner_vid, r.inner_pri, r.outer_pri,
            r.treat_new, r.pri_new, r.pri_match, r.rule_vid, r.idx};
  endfunction

  // store a rule or predict the entry result of one accepted request
  task automatic rewrite_entry(input vlan_req_t r);
    int unsigned n;
    entry_res_t  res;
    logic        dropped;
    logic        found;
    if (r.act == ACT_WRITE_RULE) begin
      if (r.idx < MAX_RULES)
        rule_copy[r.idx] = '{r.rule_vid, r.pri_match, r.pri_new, r.treat_new};
    end else begin
      res     = '{r.inner_pri, r.inner_treat, 1'b0};
      dropped = 1'b0;
      found   = 1'b0;
      // only single-tag, non-default entries walk the rules
      if (r.outer_pri == PRI_SINGLE_TAG && r.inner_pri < PRI_DEFAULT_MIN) begin
        n = (active_copy < MAX_RULES) ? active_copy : MAX_RULES;
        for (int i = 0; i < n && !found; i++) begin
          if (rule_copy[i].vid == r.inner_vid &&
              (rule_copy[i].pri_match[CODE_W-1] ||
               rule_copy[i].pri_match[PRI_W-1:0] == r.inner_pri &&
               rule_copy[i].pri_match[CODE_W-1:PRI_W] == '0)) begin
            found = 1'b1;
            if (rule_copy[i].pri_new == PRI_NEW_DROP) begin
              dropped = 1'b1;
            end else begin
              if (!rule_copy[i].pri_new[CODE_W-1])
                res.pri = rule_copy[i].pri_new[PRI_W-1:0];
              if (!rule_copy[i].treat_new[CODE_W-1])
                res.treat = rule_copy[i].treat_new[PRI_W-1:0];
              res.hit = 1'b1;
            end
          end
        end
      end
      if (!dropped)
        rewritten_q.push_back(res);
    end
  endtask

  // driver: one request at a time from req_queue
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready)
        rewrite_entry(req_on_bus);
      if (!in_tvalid || in_tready) begin
        if (req_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_tvalid  <= 1'b1;
          in_tuser   <= req_queue[0].act;
          in_tdata   <= pack_req(req_queue[0]);
          req_on_bus <= req_queue[0];
          req_queue.pop_front();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result with the oldest prediction
  always @(posedge clk) begin
    entry_res_t got;
    entry_res_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = '{out_tdata[PRI_W-1:0], out_tdata[2*PRI_W-1:PRI_W], out_tuser[0]};
        if (rewritten_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("unexpected result: pri %0d treat %0d hit %0d",
                     got.pri, got.treat, got.hit);
        end else begin
          want = rewritten_q.pop_front();
          if (got.pri != want.pri || got.treat != want.treat || got.hit != want.hit) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("mismatch: expected pri %0d treat %0d hit %0d, got pri %0d treat %0d hit %0d",
                       want.pri, want.treat, want.hit, got.pri, got.treat, got.hit);
          end
        end
      end
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("** vlan_rule_priority_rewriter_unit: FAILED **");
      $finish;
    end
  end

  // random helpers
  function automatic logic [CODE_W-1:0] rand_code(input int unsigned neg_pct);
    if ($urandom_range(99) < neg_pct)
      return CODE_NEG | CODE_W'($urandom_range(15));
    return CODE_W'($urandom_range(15));
  endfunction

  function automatic vlan_req_t rand_noise();
    vlan_req_t r;
    r.act         = 1'($urandom_range(1));
    r.idx         = 5'($urandom);
    r.rule_vid    = VID_W'($urandom);
    r.pri_match   = CODE_W'($urandom);
    r.pri_new     = CODE_W'($urandom);
    r.treat_new   = CODE_W'($urandom);
    r.outer_pri   = PRI_W'($urandom);
    r.inner_pri   = PRI_W'($urandom);
    r.inner_vid   = VID_W'($urandom);
    r.inner_treat = PRI_W'($urandom);
    return r;
  endfunction

  function automatic vlan_req_t rand_rule(input logic [4:0] idx, input logic [VID_W-1:0] vid);
    vlan_req_t r;
    r           = rand_noise();
    r.act       = ACT_WRITE_RULE;
    r.idx       = idx;
    r.rule_vid  = vid;
    r.pri_match = rand_code(40);
    r.pri_new   = ($urandom_range(99) < 25) ? PRI_NEW_DROP : rand_code(25);
    r.treat_new = rand_code(30);
    return r;
  endfunction

  function automatic vlan_req_t mk_rule(input logic [4:0] idx, input logic [VID_W-1:0] vid,
                                        input logic [CODE_W-1:0] m, input logic [CODE_W-1:0] pn,
                                        input logic [CODE_W-1:0] tn);
    vlan_req_t r;
    r = '{ACT_WRITE_RULE, idx, vid, m, pn, tn, '0, '0, '0, '0};
    return r;
  endfunction

  function automatic vlan_req_t mk_entry(input logic [PRI_W-1:0] outer,
                                         input logic [PRI_W-1:0] pri,
                                         input logic [VID_W-1:0] vid,
                                         input logic [PRI_W-1:0] treat);
    vlan_req_t r;
    r = '{ACT_CLASSIFY, '0, '0, '0, '0, '0, outer, pri, vid, treat};
    return r;
  endfunction

  task automatic queue_req(input vlan_req_t r);
    if (r.act == ACT_WRITE_RULE && r.idx < MAX_RULES)
      slot_written[r.idx] = 1'b1;
    req_queue.push_back(r);
  endtask

  // wait until every request is taken and every result is back
  task automatic wait_drained();
    while (req_queue.size() != 0 || in_tvalid || rewritten_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic program_active(input logic [ACT_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    active_copy = value;
    cfg_valid <= 1'b0;
  endtask

  // never let the block read a slot that has not been written
  task automatic fill_unwritten(input int unsigned n);
    for (int i = 0; i < n && i < MAX_RULES; i++)
      if (!slot_written[i])
        queue_req(rand_rule(5'(i), VID_W'($urandom)));
  endtask

  task automatic run_random_phase(input logic [ACT_W-1:0] active, input int unsigned n);
    int unsigned pick;
    for (int k = 0; k < 6; k++)
      vid_pool[k] = VID_W'($urandom);
    fill_unwritten(active);
    wait_drained();
    program_active(active);
    // seed the table with rules on this phase's VIDs
    for (int k = 0; k < 8; k++)
      queue_req(rand_rule(5'($urandom_range(MAX_RULES - 1)), vid_pool[$urandom_range(5)]));
    for (int k = 8; k < n; k++) begin
      pick = $urandom_range(99);
      if (pick < 15) begin
        queue_req(rand_rule(5'($urandom_range(MAX_RULES - 1)), vid_pool[$urandom_range(5)]));
      end else if (pick < 85) begin
        vlan_req_t r;
        r             = rand_noise();
        r.act         = ACT_CLASSIFY;
        r.outer_pri   = PRI_SINGLE_TAG;
        r.inner_pri   = PRI_W'($urandom_range(13));
        r.inner_vid   = vid_pool[$urandom_range(5)];
        queue_req(r);
      end else begin
        queue_req(rand_noise());
      end
    end
    wait_drained();
  endtask

  // stimulus sequence
  initial begin
    for (int i = 0; i < MAX_RULES; i++)
      slot_written[i] = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // no rules in force: everything passes
    program_active(ACT_W'(0));
    queue_req(mk_entry(PRI_SINGLE_TAG, 4'd0, 13'd0, 4'd0));
    queue_req(mk_entry(4'd0, 4'd15, 13'h1fff, 4'd15));
    queue_req(mk_entry(PRI_SINGLE_TAG, 4'd13, 13'h1fff, 4'd15));
    queue_req(mk_entry(4'd14, 4'd7, 13'd1234, 4'd9));

    // wildcard, drop, keep, shadowed and other-negative rules
    queue_req(mk_rule(5'd0, 13'd100, CODE_ANY, 5'd5, CODE_KEEP));
    queue_req(mk_rule(5'd1, 13'd200, 5'd3, PRI_NEW_DROP, 5'd0));
    queue_req(mk_rule(5'd2, 13'h1fff, 5'd13, CODE_KEEP, 5'd15));
    queue_req(mk_rule(5'd3, 13'd100, 5'd0, 5'd15, 5'd7));
    queue_req(mk_rule(5'd4, 13'd0, CODE_NEG, CODE_NEG, CODE_NEG));
    queue_req(mk_rule(5'd31, 13'h1fff, 5'd15, 5'd15, 5'd15));
    wait_drained();
    program_active(ACT_W'(5));

    queue_req(mk_entry(PRI_SINGLE_TAG, 4'd2, 13'd100, 4'd4));
    // first matching rule wins over a later one
    queue_req(mk_entry(PRI_SINGLE_TAG, 4'd0, 13'd100, 4'd9));
    queue_req(mk_entry(PRI_SINGLE_TAG, 4'd3, 13'd200, 4'd1));
    queue_req(mk_entry(PRI_SINGLE_TAG, 4'd4, 13'd200, 4'd1));
    queue_req(mk_entry(PRI_SINGLE_TAG, 4'd13, 13'h1fff, 4'd0));
    queue_req(mk_entry(PRI_SINGLE_TAG, 4'd12, 13'h1fff, 4'd6));
    queue_req(mk_entry(PRI_SINGLE_TAG, 4'd7, 13'd0, 4'd3));
    // two-tagged and default entries, and an entry no rule matches, pass untouched
    queue_req(mk_entry(4'd0, 4'd2, 13'd100, 4'd4));
    queue_req(mk_entry(PRI_SINGLE_TAG, PRI_DEFAULT_MIN, 13'd100, 4'd4));
    queue_req(mk_entry(PRI_SINGLE_TAG, 4'd15, 13'd100, 4'd4));
    queue_req(mk_entry(PRI_SINGLE_TAG, 4'd13, 13'd5, 4'd2));
    wait_drained();

    // oversized active count is clamped
    fill_unwritten(MAX_RULES);
    wait_drained();
    program_active(6'd63);
    queue_req(mk_entry(PRI_SINGLE_TAG, 4'd13, 13'h1fff, 4'd0));
    queue_req(mk_entry(PRI_SINGLE_TAG, 4'd1, 13'd777, 4'd8));
    wait_drained();

    // receiver idles more than sender
    send_idle_pct = 32;
    recv_idle_pct = 84;
    run_random_phase(6'd32, RAND_ITEMS);
    run_random_phase(6'd1, RAND_ITEMS);
    run_random_phase(ACT_W'($urandom_range(63)), RAND_ITEMS);

    // sender idles more than receiver
    send_idle_pct = 84;
    recv_idle_pct = 32;
    run_random_phase(6'd63, RAND_ITEMS);
    run_random_phase(6'd0, RAND_ITEMS);
    run_random_phase(6'd8, RAND_ITEMS);

    // back to back
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random_phase(6'd2, RAND_ITEMS);
    run_random_phase(ACT_W'($urandom_range(63)), RAND_ITEMS);
    run_random_phase(6'd32, RAND_ITEMS);

    if (err_cnt == 0 && rewritten_q.size() == 0)
      $display("** vlan_rule_priority_rewriter_unit: PASSED **");
    else
      $display("** vlan_rule_priority_rewriter_unit: FAILED **");
    $finish;
  end

endmodule

/* files.f */
sv/vrpr_pkg.sv
sv/vrpr_ctrl.sv
sv/vrpr_datapath.sv
sv/vlan_rule_priority_rewriter_unit.sv
bench/testbench.sv
